[src/rps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rps_pkg;

   localparam logic [63:0] WY_ADD = 64'ha0761d6478bd642f;
   localparam logic [63:0] WY_XOR = 64'he7037ed1a0b428db;

   typedef enum logic [2:0] {
      ACT_APPEND  = 3'd0,
      ACT_SHUFFLE = 3'd1,
      ACT_RESTORE = 3'd2,
      ACT_READ    = 3'd3,
      ACT_RESEED  = 3'd4,
      ACT_CLEAR   = 3'd5
   } action_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] item_value;
      logic [8:0]  position;
      logic [63:0] seed;
   } req_type;

   typedef struct packed {
      logic [15:0] item_value_out;
      logic [9:0]  pile_count;
      logic [1:0]  status;
   } rsp_type;

   // multiplier start between sequencer and the shared unit
   typedef struct packed {
      logic start;
   } mul_ctl_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_APP,
      S_RD0, S_RD1, S_RD2,
      S_RS_RD, S_RS_WAIT, S_RS_WR,
      S_GEN_ADD, S_GEN_MUL, S_GEN_WAIT, S_DRAW_MUL, S_DRAW_WAIT,
      S_REM, S_CHECK,
      S_SW_RD, S_SW_WAIT, S_SW_WR0, S_SW_WR1,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

[src/rps_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module rps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[src/rps_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// 64x64 multiply, one 32x32 partial product per cycle while busy
module rps_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rps_pkg::mul_ctl_type ctl,
   input  wire logic [63:0]         a,
   input  wire logic [63:0]         b,
   output logic                     done,
   output logic [127:0]             product
);
   import rps_pkg::*;

   logic [63:0]  a_ff, b_ff;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   step_ff, step_in;
   logic         busy_ff, busy_in;
   logic [31:0]  op_a, op_b;
   logic [63:0]  pp;

   always_comb begin
      op_a = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      op_b = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = {32'd0, op_a} * {32'd0, op_b};
      acc_in = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         acc_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + ({64'd0, pp} << (32 * (step_ff[1] + step_ff[0])));
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd3) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
      if (ctl.start) begin
         a_ff <= a;
         b_ff <= b;
      end
   end

   assign done = !busy_ff && step_ff == 3'd4;
   assign product = acc_ff;
endmodule
`default_nettype wire

[src/random_permutation_shuffler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  payload
// req       in         action, item_value, position, seed
// rsp       out        item_value_out, pile_count, status
// read: the ram read is skipped when the position is out of range
// restore: one read and write per pile entry
// shuffle: per position, two 4-step multiplies in the shared multiplier and a
// ram swap, plus a bit-serial 64-bit remainder once the low half falls below the
// bound, and a fresh draw for each rejected one
// reset clears count and generator; pile contents are undefined until written
// req_ready stays low from accept until the result word is taken
module random_permutation_shuffler_unit #(
   parameter int PILE_SIZE  = 512,
   parameter int ITEM_WIDTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rps_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rps_pkg::rsp_type       rsp_data
);
   import rps_pkg::*;

   localparam int AW = $clog2(PILE_SIZE);
   localparam int CW = $clog2(PILE_SIZE + 1);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [63:0] gen_ff, gen_in;
   logic [CW-1:0] i_ff, i_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [63:0] rem_ff, rem_in, num_ff, num_in;
   logic [6:0]  bit_ff, bit_in;
   logic        remok_ff, remok_in;
   logic [AW-1:0] pick_ff, pick_in;
   logic [ITEM_WIDTH-1:0] top_ff, top_in;
   rsp_type rsp_ff, rsp_in;

   mul_ctl_type mctl;
   logic [63:0] ma, mb;
   logic        mdone;
   logic [127:0] mprod;

   logic w_we, l_we;
   logic [AW-1:0] w_wa, w_ra, l_wa, l_ra;
   logic [ITEM_WIDTH-1:0] w_wd, w_rd, l_wd, l_rd;
   logic [63:0] bound, rem_sh;

   rps_mul u_mul (.clock, .reset, .ctl(mctl), .a(ma), .b(mb), .done(mdone),
      .product(mprod));
   rps_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(PILE_SIZE)) u_work (.clock, .wr_en(w_we),
      .wr_addr(w_wa), .wr_data(w_wd), .rd_addr(w_ra), .rd_data(w_rd));
   rps_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(PILE_SIZE)) u_load (.clock, .wr_en(l_we),
      .wr_addr(l_wa), .wr_data(l_wd), .rd_addr(l_ra), .rd_data(l_rd));

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      gen_in = gen_ff;
      i_in = i_ff;
      x_in = x_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      bit_in = bit_ff;
      remok_in = remok_ff;
      pick_in = pick_ff;
      top_in = top_ff;
      rsp_in = rsp_ff;
      mctl.start = 1'b0;
      ma = gen_ff;
      mb = gen_ff ^ WY_XOR;
      w_we = 1'b0;
      l_we = 1'b0;
      w_wa = count_ff[AW-1:0];
      l_wa = count_ff[AW-1:0];
      w_wd = ITEM_WIDTH'(req_ff.item_value);
      l_wd = ITEM_WIDTH'(req_ff.item_value);
      w_ra = AW'(req_ff.position);
      l_ra = i_ff[AW-1:0];
      bound = 64'(i_ff);
      rem_sh = {rem_ff[62:0], num_ff[63]};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rsp_in = '0;
               i_in = '0;
               unique case (req_data.action)
                  ACT_APPEND: state_in = S_APP;
                  ACT_SHUFFLE: begin
                     i_in = count_ff;
                     state_in = count_ff > CW'(1) ? S_GEN_ADD : S_RESP;
                  end
                  ACT_RESTORE: state_in = S_RS_RD;
                  ACT_READ: state_in = S_RD0;
                  ACT_RESEED: begin
                     gen_in = req_data.seed;
                     state_in = S_RESP;
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
               rsp_in.pile_count = 10'(state_in == S_IDLE ? count_ff : count_in);
            end
         end
         S_APP: begin
            if (count_ff < CW'(PILE_SIZE)) begin
               w_we = 1'b1;
               l_we = 1'b1;
               count_in = count_ff + CW'(1);
            end else begin
               rsp_in.status = ST_FULL;
            end
            rsp_in.pile_count = 10'(count_in);
            state_in = S_RESP;
         end
         S_RD0: begin
            if (32'(req_ff.position) < 32'(count_ff) &&
                  32'(req_ff.position) < PILE_SIZE) begin
               state_in = S_RD1;
            end else begin
               rsp_in.status = ST_RANGE;
               state_in = S_RESP;
            end
         end
         S_RD1: state_in = S_RD2;
         S_RD2: begin
            rsp_in.item_value_out = 16'(w_rd);
            state_in = S_RESP;
         end
         S_RS_RD: state_in = i_ff < count_ff ? S_RS_WAIT : S_RESP;
         S_RS_WAIT: state_in = S_RS_WR;
         S_RS_WR: begin
            w_we = 1'b1;
            w_wa = i_ff[AW-1:0];
            w_wd = l_rd;
            i_in = i_ff + CW'(1);
            state_in = S_RS_RD;
         end
         S_GEN_ADD: begin
            gen_in = gen_ff + WY_ADD;
            state_in = S_GEN_MUL;
         end
         S_GEN_MUL: begin
            mctl.start = 1'b1;
            state_in = S_GEN_WAIT;
         end
         S_GEN_WAIT: begin
            if (mdone) begin
               x_in = mprod[127:64] ^ mprod[63:0];
               state_in = S_DRAW_MUL;
            end
         end
         S_DRAW_MUL: begin
            ma = x_ff;
            mb = bound;
            mctl.start = 1'b1;
            state_in = S_DRAW_WAIT;
         end
         S_DRAW_WAIT: begin
            if (mdone) begin
               hi_in = mprod[127:64];
               lo_in = mprod[63:0];
               if (mprod[63:0] < bound && !remok_ff) begin
                  rem_in = '0;
                  num_in = 64'd0 - bound;
                  bit_in = '0;
                  state_in = S_REM;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_REM: begin
            // restoring division, one bit per cycle
            rem_in = rem_sh >= bound ? rem_sh - bound : rem_sh;
            num_in = {num_ff[62:0], 1'b0};
            bit_in = bit_ff + 7'd1;
            if (bit_ff == 7'd63) begin
               remok_in = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (remok_ff && lo_ff < rem_ff) begin
               state_in = S_GEN_ADD;
            end else begin
               remok_in = 1'b0;
               pick_in = hi_ff < 64'(PILE_SIZE) ? hi_ff[AW-1:0] : AW'(i_ff - CW'(1));
               state_in = S_SW_RD;
            end
         end
         S_SW_RD: begin
            w_ra = AW'(i_ff - CW'(1));
            state_in = S_SW_WAIT;
         end
         S_SW_WAIT: begin
            w_ra = pick_ff;
            top_in = w_rd;
            state_in = S_SW_WR0;
         end
         S_SW_WR0: begin
            w_we = 1'b1;
            w_wa = AW'(i_ff - CW'(1));
            w_wd = w_rd;
            state_in = S_SW_WR1;
         end
         S_SW_WR1: begin
            w_we = 1'b1;
            w_wa = pick_ff;
            w_wd = top_ff;
            i_in = i_ff - CW'(1);
            state_in = i_ff > CW'(2) ? S_GEN_ADD : S_RESP;
         end
         S_RESP: begin
            rsp_in.pile_count = 10'(count_ff);
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         gen_ff <= '0;
         remok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         gen_ff <= gen_in;
         remok_ff <= remok_in;
      end
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      i_ff <= i_in;
      x_ff <= x_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      bit_ff <= bit_in;
      pick_ff <= pick_in;
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PILE_SIZE)) else $error("count overflow");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during response");
   a_swap: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SW_WR0 |=> state_ff == S_SW_WR1) else $error("swap broken");
   a_remdone: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REM && bit_ff == 7'd63 |=> state_ff == S_CHECK)
      else $error("remainder broken");
endmodule
`default_nettype wire

[test/tb_random_permutation_shuffler_unit.sv]
`timescale 1ns / 1ps
module tb_random_permutation_shuffler_unit;
   import rps_pkg::*;

   localparam int PILE_SIZE = 512;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   random_permutation_shuffler_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // shadow copy of the block
   logic [15:0] pile_now [PILE_SIZE];
   logic [15:0] pile_orig [PILE_SIZE];
   int unsigned pile_len;
   logic [63:0] rng_state;

   req_type words_to_send [$];
   rsp_type expected_words [$];
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_off = 0;
   int      errors = 0;

   function automatic logic [127:0] wide_mul(logic [63:0] a, logic [63:0] b);
      return {64'd0, a} * {64'd0, b};
   endfunction

   function automatic logic [63:0] rng_next();
      logic [127:0] p;
      rng_state = rng_state + WY_ADD;
      p = wide_mul(rng_state, rng_state ^ WY_XOR);
      return p[127:64] ^ p[63:0];
   endfunction

   function automatic logic [63:0] bounded_draw(logic [63:0] bound);
      logic [127:0] p;
      logic [63:0]  thresh;
      p = wide_mul(rng_next(), bound);
      if (p[63:0] < bound) begin
         thresh = (64'd0 - bound) % bound;
         while (p[63:0] < thresh) p = wide_mul(rng_next(), bound);
      end
      return p[127:64];
   endfunction

   function automatic rsp_type predict_shuffler(req_type r);
      rsp_type     o;
      int unsigned top, pick;
      logic [15:0] tmp;
      o = '0;
      case (r.action)
         ACT_APPEND: begin
            if (pile_len < PILE_SIZE) begin
               pile_now[pile_len] = r.item_value;
               pile_orig[pile_len] = r.item_value;
               pile_len++;
            end else o.status = ST_FULL;
         end
         ACT_SHUFFLE: begin
            for (int unsigned i = pile_len; i > 1; i--) begin
               top = i - 1;
               pick = int'(bounded_draw(64'(i)));
               if (pick >= PILE_SIZE) pick = top;
               tmp = pile_now[top];
               pile_now[top] = pile_now[pick];
               pile_now[pick] = tmp;
            end
         end
         ACT_RESTORE: for (int i = 0; i < pile_len; i++) pile_now[i] = pile_orig[i];
         ACT_READ: begin
            if (r.position < pile_len) o.item_value_out = pile_now[r.position];
            else o.status = ST_RANGE;
         end
         ACT_RESEED: rng_state = r.seed;
         ACT_CLEAR: pile_len = 0;
         default: ;
      endcase
      o.pile_count = 10'(pile_len);
      return o;
   endfunction

   function automatic req_type make_word(logic [2:0] act, logic [15:0] v,
                                         logic [8:0] pos, logic [63:0] sd);
      req_type r;
      r.action = act;
      r.item_value = v;
      r.position = pos;
      r.seed = sd;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type random_word();
      logic [2:0] act;
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 40) act = ACT_APPEND;
      else if (k < 50) act = ACT_SHUFFLE;
      else if (k < 56) act = ACT_RESTORE;
      else if (k < 88) act = ACT_READ;
      else if (k < 93) act = ACT_RESEED;
      else if (k < 96) act = ACT_CLEAR;
      else act = 3'($urandom_range(6, 7));
      return make_word(act, 16'($urandom), 9'($urandom), rand64());
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (words_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data <= words_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) expected_words.push_back(predict_shuffler(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t unexpected word %h", $time, rsp_data);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.item_value_out !== want.item_value_out) begin
                  $display("%0t item_value_out exp %h got %h", $time,
                           want.item_value_out, rsp_data.item_value_out);
                  errors++;
               end
               if (rsp_data.pile_count !== want.pile_count) begin
                  $display("%0t pile_count exp %0d got %0d", $time,
                           want.pile_count, rsp_data.pile_count);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t status exp %0d got %0d", $time,
                           want.status, rsp_data.status);
                  errors++;
               end
            end
         end
      end
   end

   task automatic drain();
      while (words_to_send.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      pile_len = 0;
      rng_state = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed
      words_to_send.push_back(make_word(ACT_READ, 16'h0, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_SHUFFLE, 16'h0, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_APPEND, 16'hffff, 9'h1ff, '1));
      words_to_send.push_back(make_word(ACT_SHUFFLE, 16'h0, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_APPEND, 16'h0000, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_APPEND, 16'ha5a5, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_SHUFFLE, 16'h0, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_APPEND, 16'h5a5a, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_READ, 16'h0, 9'd0, '0));
      words_to_send.push_back(make_word(ACT_READ, 16'h0, 9'd3, '0));
      words_to_send.push_back(make_word(ACT_READ, 16'h0, 9'h1ff, '0));
      words_to_send.push_back(make_word(ACT_RESEED, 16'hffff, 9'h1ff, 64'hffffffffffffffff));
      words_to_send.push_back(make_word(ACT_SHUFFLE, 16'h0, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_READ, 16'h0, 9'd2, '0));
      words_to_send.push_back(make_word(ACT_RESTORE, 16'h0, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_READ, 16'h0, 9'd1, '0));
      words_to_send.push_back(make_word(3'd6, 16'hffff, 9'h1ff, '1));
      words_to_send.push_back(make_word(3'd7, 16'h0, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_CLEAR, 16'h0, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_READ, 16'h0, 9'd0, '0));
      // build a larger pile
      for (int i = 0; i < 40; i++)
         words_to_send.push_back(make_word(ACT_APPEND, 16'($urandom), 9'($urandom), '0));
      words_to_send.push_back(make_word(ACT_APPEND, 16'h1234, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_RESEED, 16'h0, 9'h0, rand64()));
      words_to_send.push_back(make_word(ACT_SHUFFLE, 16'h0, 9'h0, '0));
      words_to_send.push_back(make_word(ACT_READ, 16'h0, 9'h1ff, '0));
      words_to_send.push_back(make_word(ACT_CLEAR, 16'h0, 9'h0, '0));
      // long receiver stall while sender keeps offering
      hold_off = 300;
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 68 : 0;
         recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 34 : 0;
         for (int n = 0; n < 75; n++) words_to_send.push_back(random_word());
         drain();
      end
      repeat (50) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #200ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
